// ----- rtl/modexp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, defaults and status types for the modular exponentiation
// block.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int unsigned MOD_BITS_DEF = 31;
   localparam int unsigned EXP_BITS_DEF = 32;

   localparam int unsigned MODULUS_W = 31;
   localparam int unsigned BASE_W    = 31;
   localparam int unsigned EXPON_W   = 32;
   localparam int unsigned RESULT_W  = 31;

   localparam logic [MODULUS_W-1:0] RESET_MODULUS = 31'd1000000007;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

endpackage : modexp_pkg
`default_nettype wire

// ----- rtl/modexp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_if
// Valid/ready channels for requests and responses of the exponentiation block.
// ----------------------------------------------------------------------------
interface modexp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic [modexp_pkg::BASE_W-1:0]      base;
   logic [modexp_pkg::EXPON_W-1:0]     exponent;

   modport source (output valid, output mode, output base, output exponent,
                   input ready);
   modport sink   (input valid, input mode, input base, input exponent,
                   output ready);
endinterface : modexp_req_if

interface modexp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [modexp_pkg::RESULT_W-1:0]    result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface : modexp_rsp_if
`default_nettype wire

// ----- rtl/modexp_mulmod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial interleaved modular multiplier: one bit of x per cycle, MSB
// first, r = 2r + bit*y reduced by m or 2m. y must be below m.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
   parameter int unsigned MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [MOD_BITS-1:0]       op_x,
   input  wire logic [MOD_BITS-1:0]       op_y,
   input  wire logic [MOD_BITS-1:0]       modulus,
   output logic [MOD_BITS-1:0]            product,
   output modexp_pkg::mm_status_type      status
);

   localparam int unsigned CW = $clog2(MOD_BITS);
   localparam int unsigned SW = MOD_BITS + 2;

   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [MOD_BITS-1:0] y_ff, y_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [SW-1:0] sum;
   logic [SW-1:0] m1;
   logic [SW-1:0] m2;
   logic [SW-1:0] diff1;
   logic [SW-1:0] diff2;
   logic [MOD_BITS-1:0] r_step;

   always_comb begin
      m1    = SW'(modulus);
      m2    = SW'({modulus, 1'b0});
      sum   = SW'({r_ff, 1'b0}) + (x_ff[MOD_BITS-1] ? SW'(y_ff) : '0);
      diff1 = sum - m1;
      diff2 = sum - m2;
      if (sum >= m2) begin
         r_step = diff2[MOD_BITS-1:0];
      end else if (sum >= m1) begin
         r_step = diff1[MOD_BITS-1:0];
      end else begin
         r_step = sum[MOD_BITS-1:0];
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = op_x;
         y_in    = op_y;
         r_in    = '0;
         cnt_in  = CW'(MOD_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[MOD_BITS-2:0], 1'b0};
         r_in = r_step;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign product     = r_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule : modexp_mulmod
`default_nettype wire

// ----- rtl/modexp_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_seq
// Square-and-multiply sequencer: scans the exponent LSB first and drives the
// shared serial multiplier for base reduction, multiplies and squarings.
// ----------------------------------------------------------------------------
module modexp_seq #(
   parameter int unsigned MOD_BITS = modexp_pkg::MOD_BITS_DEF,
   parameter int unsigned EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              mode,
   input  wire logic [modexp_pkg::BASE_W-1:0]     base,
   input  wire logic [modexp_pkg::EXPON_W-1:0]    exponent,
   input  wire logic [MOD_BITS-1:0]               modulus,
   input  wire logic                              slot_free,
   output logic [modexp_pkg::RESULT_W-1:0]        result,
   output modexp_pkg::seq_status_type             status
);

   localparam int unsigned WA = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;
   localparam int unsigned WX = (WA > modexp_pkg::EXPON_W) ? WA : modexp_pkg::EXPON_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_SQR    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [EXP_BITS-1:0] e_ff, e_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic [MOD_BITS-1:0] m_ff, m_in;
   logic [MOD_BITS-1:0] one_ff, one_in;
   logic                mm_start_ff, mm_start_in;

   logic [WX-1:0]       inv_exp;
   logic [WX-1:0]       raw_exp;
   logic [MOD_BITS-1:0] m_eff;
   logic [MOD_BITS-1:0] mm_x;
   logic [MOD_BITS-1:0] mm_y;
   logic [MOD_BITS-1:0] mm_product;
   logic                e_upper_nz;
   modexp_pkg::mm_status_type mm_status;

   modexp_mulmod #(
      .MOD_BITS (MOD_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start_ff),
      .op_x    (mm_x),
      .op_y    (mm_y),
      .modulus (m_ff),
      .product (mm_product),
      .status  (mm_status)
   );

   always_comb begin
      inv_exp = WX'(modulus) - WX'(2);
      raw_exp = WX'(exponent);
      m_eff   = (modulus == '0) ? MOD_BITS'(1) : modulus;
   end

   always_comb begin
      case (state_ff)
         S_REDUCE: begin
            mm_x = sq_ff;
            mm_y = one_ff;
         end
         S_MUL: begin
            mm_x = acc_ff;
            mm_y = sq_ff;
         end
         default: begin
            mm_x = sq_ff;
            mm_y = sq_ff;
         end
      endcase
   end

   assign e_upper_nz = (e_ff[EXP_BITS-1:1] != '0);

   always_comb begin
      state_in    = state_ff;
      e_in        = e_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      m_in        = m_ff;
      one_in      = one_ff;
      mm_start_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               e_in        = mode ? inv_exp[EXP_BITS-1:0] : raw_exp[EXP_BITS-1:0];
               acc_in      = MOD_BITS'(1);
               sq_in       = base[MOD_BITS-1:0];
               m_in        = m_eff;
               one_in      = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
               mm_start_in = 1'b1;
               state_in    = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (mm_status.done) begin
               sq_in    = mm_product;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (e_ff == '0) begin
               state_in = S_DONE;
            end else if (e_ff[0]) begin
               mm_start_in = 1'b1;
               state_in    = S_MUL;
            end else begin
               mm_start_in = 1'b1;
               state_in    = S_SQR;
            end
         end
         S_MUL: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               if (e_upper_nz) begin
                  mm_start_in = 1'b1;
                  state_in    = S_SQR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SQR: begin
            if (mm_status.done) begin
               sq_in    = mm_product;
               e_in     = {1'b0, e_ff[EXP_BITS-1:1]};
               state_in = S_DECIDE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mm_start_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mm_start_ff <= mm_start_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      m_ff   <= m_in;
      one_ff <= one_in;
   end

   assign result      = modexp_pkg::RESULT_W'(acc_ff);
   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_DONE) && slot_free;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_status.done |-> (state_ff == S_REDUCE || state_ff == S_MUL || state_ff == S_SQR))
      else $error("multiplier finished outside a wait state");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mm_start_ff |-> !mm_status.busy)
      else $error("multiplier started while busy");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && mm_status.done) |=> (acc_ff < m_ff))
      else $error("accumulator not reduced after multiply");

   a_exp_hold_in_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |=> $stable(e_ff))
      else $error("exponent changed during multiply");
`endif

endmodule : modexp_seq
`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation with a
// configurable modulus and a Fermat inverse mode.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// req_if    in   valid/ready    mode, base, exponent
// rsp_if    out  valid/ready    result
// csr_*     in   csr_wr_en      csr_wr_data (modulus)
//
// One transaction at a time; every product is computed in the
// shared bit-serial multiplier: one base reduction, one product per set
// exponent bit, one squaring per bit below the top set bit, and one
// decision state per exponent bit.
// Synchronous reset sets the modulus to 1000000007 and empties the response
// register; completion stalls only while that register is full.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int unsigned MOD_BITS = modexp_pkg::MOD_BITS_DEF,
   parameter int unsigned EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   modexp_req_if.sink                               req_if,
   modexp_rsp_if.source                             rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [modexp_pkg::MODULUS_W-1:0]    csr_wr_data
);

   logic [MOD_BITS-1:0]               csr_modulus_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [modexp_pkg::RESULT_W-1:0]   rsp_result_ff, rsp_result_in;
   logic [modexp_pkg::RESULT_W-1:0]   seq_result;
   logic                              slot_free;
   logic                              req_take;
   modexp_pkg::seq_status_type        seq_status;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign req_take  = req_if.valid && seq_status.idle;

   modexp_seq #(
      .MOD_BITS (MOD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .mode      (req_if.mode),
      .base      (req_if.base),
      .exponent  (req_if.exponent),
      .modulus   (csr_modulus_ff),
      .slot_free (slot_free),
      .result    (seq_result),
      .status    (seq_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_modulus_ff <= modexp_pkg::RESET_MODULUS[MOD_BITS-1:0];
      end else if (csr_wr_en) begin
         csr_modulus_ff <= csr_wr_data[MOD_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (seq_status.done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = seq_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign req_if.ready  = seq_status.idle;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.result = rsp_result_ff;

endmodule : modular_exponentiation
`default_nettype wire
